/* sv/piau_pkg.sv */
// ----------------------------------------------------------------------------
// piau_pkg: shared types and codes for the integer arithmetic unit
// Instruction codes, the decoded command passed from front to back, and the
// operation classes used by the execute stage.
// ----------------------------------------------------------------------------
package piau_pkg;

   localparam logic [4:0] MODE_ADDI   = 5'd0;
   localparam logic [4:0] MODE_ADD    = 5'd1;
   localparam logic [4:0] MODE_ADDC   = 5'd2;
   localparam logic [4:0] MODE_ADDE   = 5'd3;
   localparam logic [4:0] MODE_ADDZE  = 5'd4;
   localparam logic [4:0] MODE_ADDME  = 5'd5;
   localparam logic [4:0] MODE_ADDIC  = 5'd6;
   localparam logic [4:0] MODE_SUBF   = 5'd7;
   localparam logic [4:0] MODE_SUBFIC = 5'd8;
   localparam logic [4:0] MODE_SUBFC  = 5'd9;
   localparam logic [4:0] MODE_SUBFE  = 5'd10;
   localparam logic [4:0] MODE_SUBFZE = 5'd11;
   localparam logic [4:0] MODE_DIVW   = 5'd12;
   localparam logic [4:0] MODE_DIVWU  = 5'd13;
   localparam logic [4:0] MODE_MULHW  = 5'd14;
   localparam logic [4:0] MODE_MULHWU = 5'd15;
   localparam logic [4:0] MODE_MULLW  = 5'd16;
   localparam logic [4:0] MODE_MULLI  = 5'd17;
   localparam logic [4:0] MODE_LOAD   = 5'd18;
   localparam logic [4:0] MODE_READ   = 5'd19;
   localparam logic [4:0] MODE_XER    = 5'd20;

   localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
   localparam logic [31:0] WORD_MASK = 32'hffff_ffff;

   // Decoded command held in the queue between front and back.
   typedef struct packed {
      logic [4:0]  mode;
      logic [4:0]  dest_reg;
      logic [4:0]  src_a_reg;
      logic [4:0]  src_b_reg;
      logic [31:0] imm_ext;
      logic [31:0] load_value;
      logic        overflow_enable;
      logic        record_cr0;
      logic        is_div;
      logic        is_mul;
   } piau_cmd_type;

   // One result beat.
   typedef struct packed {
      logic [31:0] value;
      logic        reg_written;
      logic [3:0]  cr0;
      logic        cr0_valid;
      logic        carry;
      logic        overflow;
      logic        summary_overflow;
   } piau_rsp_type;

endpackage

/* sv/piau_front.sv */
// ----------------------------------------------------------------------------
// piau_front: request decode and command queue
// Accepts request beats, sign extends the immediate, classifies the
// instruction and holds commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module piau_front
   import piau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [4:0]         req_mode,
   input  logic [4:0]         req_dest_reg,
   input  logic [4:0]         req_src_a_reg,
   input  logic [4:0]         req_src_b_reg,
   input  logic [15:0]        req_immediate,
   input  logic [31:0]        req_load_value,
   input  logic               req_overflow_enable,
   input  logic               req_record_cr0,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output piau_cmd_type       cmd
);

   piau_cmd_type q_ff [2];
   piau_cmd_type q_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   // Classify the incoming beat.
   always_comb begin
      q_in.mode            = req_mode;
      q_in.dest_reg        = req_dest_reg;
      q_in.src_a_reg       = req_src_a_reg;
      q_in.src_b_reg       = req_src_b_reg;
      q_in.imm_ext         = {{16{req_immediate[15]}}, req_immediate};
      q_in.load_value      = req_load_value;
      q_in.overflow_enable = req_overflow_enable;
      q_in.record_cr0      = req_record_cr0;
      q_in.is_div          = (req_mode == MODE_DIVW) || (req_mode == MODE_DIVWU);
      q_in.is_mul          = (req_mode == MODE_MULHW) || (req_mode == MODE_MULHWU) ||
                             (req_mode == MODE_MULLW) || (req_mode == MODE_MULLI);
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

/* sv/piau_back.sv */
// ----------------------------------------------------------------------------
// piau_back: execute sequencer
// Reads operands from the register file, runs adds in one step, multiplies
// in two stages and divides one quotient bit a cycle, then writes back and
// presents the result beat from an output register.
// ----------------------------------------------------------------------------
module piau_back
   import piau_pkg::*;
#(
   parameter int REG_COUNT = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  piau_cmd_type cmd,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output piau_rsp_type rsp
);

   localparam int IW = $clog2(REG_COUNT);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_MUL   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_WB    = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   piau_cmd_type c_ff;
   logic [31:0]  rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [31:0]  a_ff, b_ff, d_ff;
   logic         ca_ff, ov_ff, so_ff;
   logic [63:0]  prod_ff;
   logic [31:0]  quo_ff, rem_ff, dvs_ff;
   logic [5:0]   cnt_ff;
   logic         neg_ff;
   logic [31:0]  res_ff;
   logic         wr_ff;
   logic         dovf_ff;
   logic         rsp_valid_ff;
   piau_rsp_type rsp_ff;

   logic [IW-1:0] ia, ib, id;
   assign ia = c_ff.src_a_reg[IW-1:0];
   assign ib = c_ff.src_b_reg[IW-1:0];
   assign id = c_ff.dest_reg[IW-1:0];

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Combinational arithmetic on the latched operands.
   logic [32:0] wide;
   logic [31:0] res_c;
   logic        wr_c, setca_c;
   always_comb begin
      wide    = 33'd0;
      res_c   = 32'd0;
      wr_c    = 1'b0;
      setca_c = 1'b0;
      case (c_ff.mode)
         MODE_ADDI: begin
            res_c = (c_ff.src_a_reg == 5'd0) ? c_ff.imm_ext : a_ff + c_ff.imm_ext;
            wr_c = 1'b1;
         end
         MODE_ADD: begin
            res_c = a_ff + b_ff; wr_c = 1'b1;
         end
         MODE_SUBF: begin
            res_c = ~a_ff + b_ff + 32'd1; wr_c = 1'b1;
         end
         MODE_ADDC:   begin wide = {1'b0, a_ff} + {1'b0, b_ff}; setca_c = 1'b1; end
         MODE_ADDE:   begin
            wide = {1'b0, a_ff} + {1'b0, b_ff} + {32'd0, ca_ff}; setca_c = 1'b1;
         end
         MODE_ADDZE:  begin wide = {1'b0, a_ff} + {32'd0, ca_ff}; setca_c = 1'b1; end
         MODE_ADDME:  begin
            wide = {1'b0, a_ff} + {32'd0, ca_ff} + {1'b0, WORD_MASK}; setca_c = 1'b1;
         end
         MODE_ADDIC:  begin wide = {1'b0, a_ff} + {1'b0, c_ff.imm_ext}; setca_c = 1'b1; end
         MODE_SUBFIC: begin
            wide = {1'b0, ~a_ff} + {1'b0, c_ff.imm_ext} + 33'd1; setca_c = 1'b1;
         end
         MODE_SUBFC:  begin
            wide = {1'b0, ~a_ff} + {1'b0, b_ff} + 33'd1; setca_c = 1'b1;
         end
         MODE_SUBFE:  begin
            wide = {1'b0, ~a_ff} + {1'b0, b_ff} + {32'd0, ca_ff}; setca_c = 1'b1;
         end
         MODE_SUBFZE: begin wide = {1'b0, ~a_ff} + {32'd0, ca_ff}; setca_c = 1'b1; end
         MODE_LOAD:   begin res_c = c_ff.load_value; wr_c = 1'b1; end
         default: ;
      endcase
      if (setca_c) begin
         res_c = wide[31:0];
         wr_c  = 1'b1;
      end
   end

   // Multiplier operands: signed forms sign extend to 33 bits.
   logic        mul_sgn;
   logic [32:0] ma, mb;
   logic [65:0] mfull;
   always_comb begin
      mul_sgn = (c_ff.mode != MODE_MULHWU);
      ma = {mul_sgn & a_ff[31], a_ff};
      mb = (c_ff.mode == MODE_MULLI) ? {c_ff.imm_ext[31], c_ff.imm_ext}
                                     : {mul_sgn & b_ff[31], b_ff};
      mfull = 66'($signed(ma) * $signed(mb));
   end

   // Divider step and setup.
   logic        dv_signed, dv_ovf;
   logic [31:0] mag_a, mag_b;
   logic [32:0] trial;
   logic [31:0] rem_sh;
   always_comb begin
      dv_signed = (c_ff.mode == MODE_DIVW);
      dv_ovf    = (b_ff == 32'd0) ||
                  (dv_signed && a_ff == SIGN_BIT && b_ff == WORD_MASK);
      mag_a     = (dv_signed && a_ff[31]) ? (~a_ff + 32'd1) : a_ff;
      mag_b     = (dv_signed && b_ff[31]) ? (~b_ff + 32'd1) : b_ff;
      rem_sh    = {rem_ff[30:0], quo_ff[31]};
      trial     = {rem_ff[31], rem_sh} - {1'b0, dvs_ff};
   end

   // CR0 and reported flags for the write-back beat.
   logic [31:0] newv;
   logic        nov, nso, rec;
   always_comb begin
      newv = wr_ff ? res_ff : d_ff;
      nov  = ov_ff;
      nso  = so_ff;
      rec  = 1'b0;
      if (c_ff.overflow_enable && (c_ff.is_div || c_ff.mode == MODE_MULLW)) begin
         nov = dovf_ff;
         nso = so_ff | dovf_ff;
      end
      if (c_ff.mode == MODE_XER) begin
         nov = c_ff.load_value[1];
         nso = c_ff.load_value[2];
      end
      case (c_ff.mode)
         MODE_ADD, MODE_ADDC, MODE_ADDE, MODE_ADDZE, MODE_ADDME, MODE_ADDIC,
         MODE_SUBF, MODE_SUBFC, MODE_SUBFE, MODE_SUBFZE, MODE_DIVW, MODE_DIVWU,
         MODE_MULHW, MODE_MULHWU, MODE_MULLW: rec = c_ff.record_cr0;
         default: rec = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) state_in = ST_READ;
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (c_ff.is_div && !dv_ovf) state_in = ST_DIV;
            else if (c_ff.is_mul) state_in = ST_MUL;
            else state_in = ST_WB;
         end
         ST_MUL: state_in = ST_WB;
         ST_DIV: if (cnt_ff == 6'd31) state_in = ST_WB;
         ST_WB: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         ca_ff        <= 1'b0;
         ov_ff        <= 1'b0;
         so_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EXEC && setca_c) ca_ff <= wide[32];
         if (state_ff == ST_WB && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
            ov_ff <= nov;
            so_ff <= nso;
            if (c_ff.mode == MODE_XER) ca_ff <= c_ff.load_value[0];
            if (wr_ff) vld_ff[id] <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers and the register file.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: if (cmd_valid) c_ff <= cmd;
         ST_READ: begin
            a_ff <= vld_ff[ia] ? rf_ff[ia] : 32'd0;
            b_ff <= vld_ff[ib] ? rf_ff[ib] : 32'd0;
            d_ff <= vld_ff[id] ? rf_ff[id] : 32'd0;
         end
         ST_EXEC: begin
            res_ff  <= res_c;
            wr_ff   <= wr_c || c_ff.is_mul || (c_ff.is_div && !dv_ovf);
            dovf_ff <= c_ff.is_div ? dv_ovf : 1'b0;
            prod_ff <= mfull[63:0];
            quo_ff  <= mag_a;
            rem_ff  <= 32'd0;
            dvs_ff  <= mag_b;
            cnt_ff  <= 6'd0;
            neg_ff  <= dv_signed && (a_ff[31] ^ b_ff[31]);
         end
         ST_MUL: begin
            if (c_ff.mode == MODE_MULHW || c_ff.mode == MODE_MULHWU)
               res_ff <= prod_ff[63:32];
            else
               res_ff <= prod_ff[31:0];
            dovf_ff <= (prod_ff[63:31] != 33'd0) && (prod_ff[63:31] != {33{1'b1}});
         end
         ST_DIV: begin
            cnt_ff <= cnt_ff + 6'd1;
            if (!trial[32]) begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd31) begin
               if (!trial[32])
                  res_ff <= neg_ff ? ~{quo_ff[30:0], 1'b1} + 32'd1 : {quo_ff[30:0], 1'b1};
               else
                  res_ff <= neg_ff ? ~{quo_ff[30:0], 1'b0} + 32'd1 : {quo_ff[30:0], 1'b0};
            end
         end
         ST_WB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (wr_ff) rf_ff[id] <= res_ff;
               rsp_ff.value            <= newv;
               rsp_ff.reg_written      <= wr_ff;
               rsp_ff.cr0              <= rec ? {newv[31], !newv[31] && newv != 32'd0,
                                                 newv == 32'd0, nso} : 4'd0;
               rsp_ff.cr0_valid        <= rec;
               rsp_ff.carry            <= (c_ff.mode == MODE_XER) ? c_ff.load_value[0]
                                                                   : ca_ff;
               rsp_ff.overflow         <= nov;
               rsp_ff.summary_overflow <= nso;
            end
         end
         default: ;
      endcase
   end

endmodule

/* sv/powerpc_integer_arith_unit.sv */
// ----------------------------------------------------------------------------
// powerpc_integer_arith_unit: 32-bit integer arithmetic unit
// Executes one integer add, subtract, multiply or divide instruction per
// beat against a 32-entry register file and the XER flags.
//
//   Channel   Direction  Handshake        Payload
//   req       in         valid / ready    mode, registers, immediate, flags
//   rsp       out        valid / ready    value, flags, CR0
//
// Adds, loads and reads go through read, execute and write-back; multiplies
// add a two-stage multiplier, divides one quotient bit a cycle in the shared
// divider. A two-entry queue takes new beats while the back end works.
// Reset is synchronous; register-file valid bits clear at once, no sweep.
// A stalled response holds the back end in write-back; the queue still fills.
// ----------------------------------------------------------------------------
module powerpc_integer_arith_unit
   import piau_pkg::*;
#(
   parameter int REG_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_mode,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_a_reg,
   input  logic [4:0]  req_src_b_reg,
   input  logic [15:0] req_immediate,
   input  logic [31:0] req_load_value,
   input  logic        req_overflow_enable,
   input  logic        req_record_cr0,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_value,
   output logic        rsp_reg_written,
   output logic [3:0]  rsp_cr0,
   output logic        rsp_cr0_valid,
   output logic        rsp_carry,
   output logic        rsp_overflow,
   output logic        rsp_summary_overflow
);

   logic         cmd_valid, cmd_ready;
   piau_cmd_type cmd;
   piau_rsp_type rsp;

   piau_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_dest_reg,
      .req_src_a_reg, .req_src_b_reg, .req_immediate, .req_load_value,
      .req_overflow_enable, .req_record_cr0,
      .cmd_valid, .cmd_ready, .cmd
   );

   piau_back #(.REG_COUNT(REG_COUNT)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp
   );

   assign rsp_value            = rsp.value;
   assign rsp_reg_written      = rsp.reg_written;
   assign rsp_cr0              = rsp.cr0;
   assign rsp_cr0_valid        = rsp.cr0_valid;
   assign rsp_carry            = rsp.carry;
   assign rsp_overflow         = rsp.overflow;
   assign rsp_summary_overflow = rsp.summary_overflow;

endmodule

/* sv/piau_checker.sv */
// ----------------------------------------------------------------------------
// piau_checker: port-level checks for the arithmetic unit
// Watches the response channel for handshake and flag consistency.
// ----------------------------------------------------------------------------
module piau_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic [3:0]  rsp_cr0,
   input logic        rsp_cr0_valid,
   input logic        rsp_summary_overflow
);

   // A stalled response beat holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("response changed while stalled");

   // CR0 is zero unless recorded.
   a_cr0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cr0_valid |-> rsp_cr0 == 4'd0)
      else $error("cr0 set without record");

   // Recorded CR0 has exactly one of LT, GT, EQ and copies SO.
   a_cr0_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cr0_valid |->
         $onehot(rsp_cr0[3:1]) && rsp_cr0[0] == rsp_summary_overflow)
      else $error("malformed cr0");

   // EQ matches a zero value.
   a_cr0_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cr0_valid |-> rsp_cr0[1] == (rsp_value == 32'd0))
      else $error("cr0 EQ disagrees with value");

   // No response right after reset.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response during reset");

endmodule

bind powerpc_integer_arith_unit piau_checker u_piau_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_value, .rsp_cr0,
   .rsp_cr0_valid, .rsp_summary_overflow
);
